[src/look_disk_request_scheduler_defines.svh]
// Assertion macros shared by the scheduler modules.
`ifndef LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_REQUEST_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define LDRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");
`define LDRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define LDRS_ASSERT(lbl, clk, rst_n, prop)
`define LDRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/ldrs_pkg.sv]
// Types, widths and codes shared by the scheduler modules.
package ldrs_pkg;

    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int TAG_W           = 8;
    localparam int SEC_W           = 48;
    localparam int CNT_W           = 16;
    localparam int PEND_W          = 6;
    localparam int ENT_W           = TAG_W + SEC_W + CNT_W;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED      = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;          // latch the item and set the pointer
        logic    ptr_inc;
        logic    ptr_dec;
        logic    rd_nxt;        // read at pointer plus one instead of pointer
        logic    wr_shift_up;   // read data to pointer plus one
        logic    wr_new_above;  // new request to pointer plus one
        logic    wr_new_at;     // new request to pointer
        logic    wr_shift_down; // read data to pointer
        logic    take;          // capture read data as the picked request
        logic    flip;          // reverse the sweep
        logic    fill_inc;
        logic    fill_dec;      // also moves the head past the picked request
        logic    res;           // emit a result
        t_status res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic lone;
        logic dir_up;
        logic rd_gt_new;   // read start above the new start
        logic hit;         // read start lies ahead of the head
        logic ptr_zero;
        logic ptr_last;
        logic shift_more;
    } t_stat;

endpackage

[src/look_disk_request_scheduler.sv]
// Top level of the LOOK elevator disk request scheduler.
//
// The block keeps up to QUEUE_DEPTH requests in a table sorted by start
// sector and answers each item with exactly one result, shown for one cycle
// with o_valid high; the receiver cannot stall it, so it must take every
// result when it appears. An item is accepted when start is high while busy
// is low, and busy stays high until the item's result has been issued. An
// add walks the table from the top, moving larger entries up one place
// until it meets an entry whose start is not above the new start; the new
// request is written above that entry, or at the bottom when every held
// entry lies above it. A full table or an empty dispatch answers in the
// cycle right after the accepting edge. A dispatch scans from the sweep's
// near end for the first entry ahead of the head, then closes the gap by
// moving each later entry down one place, and last updates the fill count
// and the head and issues its result. When no entry lies ahead, the end
// entry is taken and the sweep turns, unless it is the only one held. The
// table memory has a single read and a single write port. The result is
// registered and appears in the same cycle in which busy falls, so the next
// item may be accepted while the result is shown. The table needs no
// clearing after reset.
`include "look_disk_request_scheduler_defines.svh"

module look_disk_request_scheduler
    import ldrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [TAG_W-1:0]  i_request_tag,
    input  logic [SEC_W-1:0]  i_start_sector,
    input  logic [CNT_W-1:0]  i_sector_count,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [SEC_W-1:0]  o_out_start,
    output logic [CNT_W-1:0]  o_out_count,
    output logic              o_sweep_up,
    output logic [PEND_W-1:0] o_pending
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each item; the datapath owns all storage apart from the controller's state register.
    ldrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_opcode(i_opcode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ldrs_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_request_tag (i_request_tag),
        .i_start_sector(i_start_sector),
        .i_sector_count(i_sector_count),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_out_tag     (o_out_tag),
        .o_out_start   (o_out_start),
        .o_out_count   (o_out_count),
        .o_sweep_up    (o_sweep_up),
        .o_pending     (o_pending)
    );

endmodule

[src/ldrs_ctrl.sv]
// Sequencer for add and dispatch items of the scheduler.
`include "look_disk_request_scheduler_defines.svh"

module ldrs_ctrl
    import ldrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_opcode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ADD_RD  = 9'b000000010,
        S_ADD_CMP = 9'b000000100,
        S_ADD_PUT = 9'b000001000,
        S_SCN_RD  = 9'b000010000,
        S_SCN_CMP = 9'b000100000,
        S_SHF_RD  = 9'b001000000,
        S_SHF_WR  = 9'b010000000,
        S_DSP_FIN = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_ADDED;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OP_ADD) begin
                        if (i_stat.full) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_state    = i_stat.empty ? S_ADD_PUT : S_ADD_RD;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.res        = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_state    = S_SCN_RD;
                        end
                    end
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                if (i_stat.rd_gt_new) begin
                    o_cmd.wr_shift_up = 1'b1;
                    if (i_stat.ptr_zero) begin
                        n_state = S_ADD_PUT;
                    end else begin
                        o_cmd.ptr_dec = 1'b1;
                        n_state       = S_ADD_RD;
                    end
                end else begin
                    o_cmd.wr_new_above = 1'b1;
                    o_cmd.fill_inc     = 1'b1;
                    o_cmd.res          = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_ADD_PUT: begin
                o_cmd.wr_new_at = 1'b1;
                o_cmd.fill_inc  = 1'b1;
                o_cmd.res       = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCN_RD: begin
                n_state = S_SCN_CMP;
            end
            S_SCN_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_SHF_RD;
                end else if (i_stat.dir_up ? i_stat.ptr_last : i_stat.ptr_zero) begin
                    // Nothing ahead: take the end entry and reverse, except for a
                    // lone request, which keeps the sweep.
                    o_cmd.take = 1'b1;
                    o_cmd.flip = !i_stat.lone;
                    n_state    = S_SHF_RD;
                end else begin
                    o_cmd.ptr_inc = i_stat.dir_up;
                    o_cmd.ptr_dec = !i_stat.dir_up;
                    n_state       = S_SCN_RD;
                end
            end
            S_SHF_RD: begin
                o_cmd.rd_nxt = 1'b1;
                n_state      = i_stat.shift_more ? S_SHF_WR : S_DSP_FIN;
            end
            S_SHF_WR: begin
                o_cmd.wr_shift_down = 1'b1;
                o_cmd.ptr_inc       = 1'b1;
                n_state             = S_SHF_RD;
            end
            S_DSP_FIN: begin
                o_cmd.fill_dec   = 1'b1;
                o_cmd.res        = 1'b1;
                o_cmd.res_status = ST_DISPATCHED;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LDRS_ASSERT(a_no_inc_dec, i_clk, i_rst_n, !(o_cmd.fill_inc && o_cmd.fill_dec))
    `LDRS_ASSERT(a_idle_no_write, i_clk, i_rst_n, !busy |-> !(o_cmd.wr_new_at || o_cmd.wr_shift_down || o_cmd.wr_shift_up || o_cmd.wr_new_above))
    `LDRS_ASSERT_NEXT(a_res_ends_item, i_clk, i_rst_n, o_cmd.res, !busy)

endmodule

[src/ldrs_dp.sv]
// Request table, head and sweep state, and result registers of the scheduler.
`include "look_disk_request_scheduler_defines.svh"

module ldrs_dp
    import ldrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_opcode,
    input  logic [TAG_W-1:0] i_request_tag,
    input  logic [SEC_W-1:0] i_start_sector,
    input  logic [CNT_W-1:0] i_sector_count,
    output t_stat            o_stat,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [TAG_W-1:0] o_out_tag,
    output logic [SEC_W-1:0] o_out_start,
    output logic [CNT_W-1:0] o_out_count,
    output logic             o_sweep_up,
    output logic [PEND_W-1:0] o_pending
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [ENT_W-1:0] mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [ENT_W-1:0] r_new;
    logic [ENT_W-1:0] r_pick;
    logic [IW-1:0]    r_ptr, n_ptr;
    logic [FW-1:0]    r_fill, n_fill;
    logic [SEC_W-1:0] r_head, n_head;
    logic             r_dir, n_dir;

    logic             r_valid;
    logic [1:0]       r_status;
    logic [ENT_W-1:0] r_res_ent;
    logic             r_res_dir;
    logic [PEND_W-1:0] r_res_pend;

    logic [IW-1:0]    ptr_nxt;
    logic [IW:0]      ptr_p1;
    logic [IW:0]      fill_x;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    fill_last;
    logic             we;
    logic [IW-1:0]    wa;
    logic [ENT_W-1:0] wd;
    logic [SEC_W-1:0] rd_start;
    logic [SEC_W-1:0] new_start;
    logic [SEC_W-1:0] pick_start;
    logic [CNT_W-1:0] pick_count;
    logic [FW+PEND_W-1:0] fill_ext;

    assign ptr_nxt    = r_ptr + 1'b1;
    assign ptr_p1     = {1'b0, r_ptr} + 1'b1;
    assign fill_x     = (IW+1)'(r_fill);
    assign fill_last  = IW'(r_fill - 1'b1);
    assign rd_addr    = i_cmd.rd_nxt ? ptr_nxt : r_ptr;
    assign rd_start   = r_rd[SEC_W+CNT_W-1:CNT_W];
    assign new_start  = r_new[SEC_W+CNT_W-1:CNT_W];
    assign pick_start = r_pick[SEC_W+CNT_W-1:CNT_W];
    assign pick_count = r_pick[CNT_W-1:0];

    assign o_stat.empty      = (r_fill == '0);
    assign o_stat.full       = (r_fill == FW'(QUEUE_DEPTH));
    assign o_stat.lone       = (r_fill == FW'(1));
    assign o_stat.dir_up     = r_dir;
    assign o_stat.rd_gt_new  = (rd_start > new_start);
    assign o_stat.hit        = r_dir ? (rd_start > r_head) : (rd_start < r_head);
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.ptr_last   = (ptr_p1 == fill_x);
    assign o_stat.shift_more = (ptr_p1 < fill_x);

    // Table write port.
    always_comb begin
        we = i_cmd.wr_shift_up | i_cmd.wr_new_above | i_cmd.wr_new_at | i_cmd.wr_shift_down;
        wa = (i_cmd.wr_shift_up || i_cmd.wr_new_above) ? ptr_nxt : r_ptr;
        wd = (i_cmd.wr_new_above || i_cmd.wr_new_at) ? r_new : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_ptr  = r_ptr;
        n_fill = r_fill;
        n_head = r_head;
        n_dir  = r_dir;
        if (i_cmd.load) begin
            n_ptr = ((i_opcode == OP_ADD || !r_dir) && r_fill != '0) ? fill_last : '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = ptr_nxt;
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - 1'b1;
        end
        if (i_cmd.flip) begin
            n_dir = ~r_dir;
        end
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - 1'b1;
            n_head = pick_start + SEC_W'(pick_count);
        end
    end

    assign fill_ext = {{PEND_W{1'b0}}, n_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_head  <= '0;
            r_dir   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_dir   <= n_dir;
            r_valid <= i_cmd.res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_new <= {i_request_tag, i_start_sector, i_sector_count};
        end
        if (i_cmd.take) begin
            r_pick <= r_rd;
        end
        if (i_cmd.res) begin
            r_status   <= i_cmd.res_status;
            r_res_ent  <= (i_cmd.res_status == ST_DISPATCHED) ? r_pick : '0;
            r_res_dir  <= n_dir;
            r_res_pend <= fill_ext[PEND_W-1:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_tag   = r_res_ent[ENT_W-1:SEC_W+CNT_W];
    assign o_out_start = r_res_ent[SEC_W+CNT_W-1:CNT_W];
    assign o_out_count = r_res_ent[CNT_W-1:0];
    assign o_sweep_up  = r_res_dir;
    assign o_pending   = r_res_pend;

    `LDRS_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(QUEUE_DEPTH))
    `LDRS_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n, i_cmd.res && i_cmd.res_status == ST_FULL, r_fill == FW'(QUEUE_DEPTH))
    `LDRS_ASSERT_NEXT(a_dispatch_drops, i_clk, i_rst_n, i_cmd.fill_dec, r_fill == $past(r_fill) - 1'b1)

endmodule
